// ----- design/lbqm_pkg.sv -----
package lbqm_pkg;

   localparam int NUM_QUEUES  = 256;
   localparam int NUM_BLOCKS  = 512;
   localparam int BLOCK_BYTES = 256;

   // field widths of the stream payload
   localparam int Q_W     = 8;
   localparam int LEN_W   = 18;
   localparam int CNT_W   = 4;
   localparam int CAP_W   = 7;
   localparam int FREE_W  = $clog2(NUM_BLOCKS + 1);
   localparam int BLK_W   = $clog2(NUM_BLOCKS);
   localparam int OFF_W   = $clog2(BLOCK_BYTES);
   localparam int QA_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int ADDR_W  = BLK_W + OFF_W;
   localparam int CLR_N   = (NUM_BLOCKS > NUM_QUEUES) ? NUM_BLOCKS : NUM_QUEUES;
   localparam int CLR_W   = $clog2(CLR_N);
   localparam int MAX_PUT = 8;
   localparam int MAX_CAP = 64;

   // request kinds
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_DRAIN = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_QUOTA = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_QUOTA   = 2'd1;
   localparam logic [1:0] ST_NO_FREE = 2'd2;

   // classified command passed from front to back
   typedef struct packed {
      logic [1:0]       kind;
      logic [Q_W-1:0]   queue;
      logic             bad;
      logic [63:0]      bytes;
      logic [CNT_W-1:0] cnt;
      logic [CAP_W-1:0] cap;
      logic [LEN_W-1:0] quota;
   } cmd_type;

   // per-queue descriptor
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic [OFF_W-1:0] off;
      logic [BLK_W-1:0] head;
      logic [BLK_W-1:0] tail;
      logic [LEN_W-1:0] quota;
   } desc_type;

   // one response transaction
   typedef struct packed {
      logic [1:0]        status;
      logic [63:0]       data;
      logic [CNT_W-1:0]  nbytes;
      logic              last;
      logic [LEN_W-1:0]  total;
      logic [FREE_W-1:0] free;
   } rsp_type;

endpackage

// ----- design/lbqm_front.sv -----
module lbqm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [1:0]        in_kind,
   input  logic [7:0]        in_queue,
   input  logic [63:0]       in_bytes,
   input  logic [3:0]        in_cnt,
   input  logic [6:0]        in_cap,
   input  logic [17:0]       in_quota,
   output logic              cmd_valid,
   output lbqm_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   lbqm_pkg::cmd_type fifo_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   lbqm_pkg::cmd_type cls;
   logic       push;

   // classify: clamp counts and flag queues out of range
   always_comb begin
      cls.kind  = in_kind;
      cls.queue = in_queue;
      cls.bad   = (32'(in_queue) >= lbqm_pkg::NUM_QUEUES);
      cls.bytes = in_bytes;
      cls.cnt   = (in_cnt > 4'(lbqm_pkg::MAX_PUT)) ? 4'(lbqm_pkg::MAX_PUT) : in_cnt;
      cls.cap   = (in_cap > 7'(lbqm_pkg::MAX_CAP)) ? 7'(lbqm_pkg::MAX_CAP) : in_cap;
      cls.quota = in_quota;
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = fifo_ff[rd_ff];

   // advance queue pointers
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = cmd_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // hold classified commands
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ff] <= cls;
      end
   end

endmodule

// ----- design/lbqm_back.sv -----
module lbqm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  lbqm_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lbqm_pkg::rsp_type rsp
);

   localparam int BLK_W  = lbqm_pkg::BLK_W;
   localparam int OFF_W  = lbqm_pkg::OFF_W;
   localparam int LEN_W  = lbqm_pkg::LEN_W;
   localparam int FREE_W = lbqm_pkg::FREE_W;
   localparam int QA_W   = lbqm_pkg::QA_W;
   localparam int CLR_W  = lbqm_pkg::CLR_W;

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DESC  = 4'd2;
   localparam logic [3:0] S_TAKE  = 4'd3;
   localparam logic [3:0] S_TAKE2 = 4'd4;
   localparam logic [3:0] S_PW    = 4'd5;
   localparam logic [3:0] S_DRD   = 4'd6;
   localparam logic [3:0] S_DRC   = 4'd7;
   localparam logic [3:0] S_DLNK  = 4'd8;
   localparam logic [3:0] S_DCHK  = 4'd9;
   localparam logic [3:0] S_EMIT  = 4'd10;

   // memories
   lbqm_pkg::desc_type desc_mem [lbqm_pkg::NUM_QUEUES];
   logic [BLK_W-1:0]   link_mem [lbqm_pkg::NUM_BLOCKS];
   logic [7:0]         data_mem [lbqm_pkg::NUM_BLOCKS * lbqm_pkg::BLOCK_BYTES];
   lbqm_pkg::desc_type desc_q;
   logic [BLK_W-1:0]   link_q;
   logic [7:0]         data_q;

   // memory controls
   logic               desc_we;
   logic [QA_W-1:0]    desc_waddr, desc_raddr;
   lbqm_pkg::desc_type desc_wdata;
   logic               link_we;
   logic [BLK_W-1:0]   link_waddr, link_raddr, link_wdata;
   logic               data_we;
   logic [lbqm_pkg::ADDR_W-1:0] data_waddr, data_raddr;
   logic [7:0]         data_wdata;

   // control registers
   logic [3:0]         state_ff, state_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   lbqm_pkg::cmd_type  cmd_ff, cmd_in;
   lbqm_pkg::desc_type wd_ff, wd_in;
   logic [BLK_W-1:0]   cur_ff, cur_in;
   logic [OFF_W:0]     off_ff, off_in;
   logic [6:0]         idx_ff, idx_in;
   logic [6:0]         nmax_ff, nmax_in;
   logic [63:0]        acc_ff, acc_in;
   logic [3:0]         nval_ff, nval_in;
   logic               last_ff, last_in;
   logic [1:0]         status_ff, status_in;
   logic               chain_ff, chain_in;
   logic [BLK_W-1:0]   ftop_ff, ftop_in;
   logic [FREE_W-1:0]  fcnt_ff, fcnt_in;
   lbqm_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rvld_ff, rvld_in;

   // descriptor arithmetic
   logic [LEN_W:0]     pos;
   logic [OFF_W-1:0]   offm;
   logic [OFF_W:0]     room;
   logic               need;
   logic               over;
   logic [LEN_W:0]     span;
   logic               slot;

   assign rsp_valid = rvld_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      pos  = {1'b0, desc_q.len} + (LEN_W+1)'(desc_q.off);
      offm = pos[OFF_W-1:0];
      room = (OFF_W+1)'(lbqm_pkg::BLOCK_BYTES) - {1'b0, offm};
      need = (desc_q.len == '0) || (offm == '0) || ((OFF_W+1)'(cmd_ff.cnt) > room);
      over = (desc_q.quota != '0) &&
             (({1'b0, desc_q.len} + (LEN_W+1)'(cmd_ff.cnt)) > {1'b0, desc_q.quota});
      span = {1'b0, desc_q.len} + (LEN_W+1)'(desc_q.off) +
             (LEN_W+1)'(lbqm_pkg::BLOCK_BYTES - 1);
      slot = !rvld_ff || rsp_ready;
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cmd_in    = cmd_ff;
      wd_in     = wd_ff;
      cur_in    = cur_ff;
      off_in    = off_ff;
      idx_in    = idx_ff;
      nmax_in   = nmax_ff;
      acc_in    = acc_ff;
      nval_in   = nval_ff;
      last_in   = last_ff;
      status_in = status_ff;
      chain_in  = chain_ff;
      ftop_in   = ftop_ff;
      fcnt_in   = fcnt_ff;
      rsp_in    = rsp_ff;
      rvld_in   = rsp_ready ? 1'b0 : rvld_ff;
      cmd_pop   = 1'b0;

      desc_we    = 1'b0;
      desc_waddr = cmd_ff.queue[QA_W-1:0];
      desc_wdata = wd_ff;
      desc_raddr = cmd.queue[QA_W-1:0];
      link_we    = 1'b0;
      link_waddr = cur_ff;
      link_wdata = ftop_ff;
      link_raddr = cur_ff;
      data_we    = 1'b0;
      data_waddr = {cur_ff, off_ff[OFF_W-1:0]};
      data_wdata = cmd_ff.bytes[{idx_ff[2:0], 3'b000} +: 8];
      data_raddr = {cur_ff, off_ff[OFF_W-1:0]};

      case (state_ff)
         S_INIT: begin
            // build the free stack and zero the descriptors
            if (32'(clr_ff) < lbqm_pkg::NUM_BLOCKS) begin
               link_we    = 1'b1;
               link_waddr = clr_ff[BLK_W-1:0];
               link_wdata = (clr_ff == '0) ? '0 : clr_ff[BLK_W-1:0] - 1'b1;
            end
            if (32'(clr_ff) < lbqm_pkg::NUM_QUEUES) begin
               desc_we    = 1'b1;
               desc_waddr = clr_ff[QA_W-1:0];
               desc_wdata = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == lbqm_pkg::CLR_N - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop   = 1'b1;
               cmd_in    = cmd;
               acc_in    = '0;
               nval_in   = '0;
               status_in = lbqm_pkg::ST_OK;
               last_in   = 1'b1;
               state_in  = S_DESC;
            end
         end
         S_DESC: begin
            wd_in    = desc_q;
            state_in = S_EMIT;
            if (!cmd_ff.bad) begin
               case (cmd_ff.kind)
                  lbqm_pkg::REQ_PUT: begin
                     if (cmd_ff.cnt == '0) begin
                        status_in = lbqm_pkg::ST_OK;
                     end else if (over) begin
                        status_in = lbqm_pkg::ST_QUOTA;
                     end else if (need && fcnt_ff == '0) begin
                        status_in = lbqm_pkg::ST_NO_FREE;
                     end else begin
                        wd_in.len = desc_q.len + LEN_W'(cmd_ff.cnt);
                        nmax_in   = 7'(cmd_ff.cnt);
                        idx_in    = '0;
                        if (desc_q.len == '0) begin
                           wd_in.head = ftop_ff;
                           wd_in.off  = '0;
                           chain_in   = 1'b0;
                           state_in   = S_TAKE;
                        end else begin
                           cur_in   = desc_q.tail;
                           off_in   = (offm == '0) ? (OFF_W+1)'(lbqm_pkg::BLOCK_BYTES)
                                                   : {1'b0, offm};
                           state_in = S_PW;
                        end
                     end
                  end
                  lbqm_pkg::REQ_DRAIN: begin
                     if (desc_q.len != '0 && cmd_ff.cap != '0) begin
                        nmax_in  = (desc_q.len < LEN_W'(cmd_ff.cap)) ? desc_q.len[6:0]
                                                                    : cmd_ff.cap;
                        idx_in   = '0;
                        cur_in   = desc_q.head;
                        off_in   = {1'b0, desc_q.off};
                        state_in = S_DRD;
                     end
                  end
                  lbqm_pkg::REQ_CLEAR: begin
                     // return the whole chain in one link write
                     if (desc_q.len != '0) begin
                        link_we    = 1'b1;
                        link_waddr = desc_q.tail;
                        link_wdata = ftop_ff;
                        ftop_in    = desc_q.head;
                        fcnt_in    = fcnt_ff + FREE_W'(span >> OFF_W);
                     end
                     wd_in.len   = '0;
                     wd_in.off   = '0;
                     wd_in.quota = '0;
                  end
                  lbqm_pkg::REQ_QUOTA: begin
                     wd_in.quota = cmd_ff.quota;
                  end
                  default: begin
                     wd_in = desc_q;
                  end
               endcase
            end
         end
         S_TAKE: begin
            // pop the free stack, chain behind the tail when extending
            link_raddr = ftop_ff;
            if (chain_ff) begin
               link_we    = 1'b1;
               link_waddr = cur_ff;
               link_wdata = ftop_ff;
            end
            cur_in   = ftop_ff;
            off_in   = '0;
            state_in = S_TAKE2;
         end
         S_TAKE2: begin
            ftop_in  = link_q;
            fcnt_in  = fcnt_ff - 1'b1;
            state_in = S_PW;
         end
         S_PW: begin
            if (idx_ff == nmax_ff) begin
               wd_in.tail = cur_ff;
               state_in   = S_EMIT;
            end else if (off_ff == (OFF_W+1)'(lbqm_pkg::BLOCK_BYTES)) begin
               chain_in = 1'b1;
               state_in = S_TAKE;
            end else begin
               data_we = 1'b1;
               off_in  = off_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_DRD: begin
            state_in = S_DRC;
         end
         S_DRC: begin
            acc_in[{nval_ff[2:0], 3'b000} +: 8] = data_q;
            nval_in   = nval_ff + 1'b1;
            off_in    = off_ff + 1'b1;
            idx_in    = idx_ff + 1'b1;
            wd_in.len = wd_ff.len - 1'b1;
            state_in  = S_DCHK;
            // free the block once consumed or once the queue runs dry
            if (off_ff[OFF_W-1:0] == OFF_W'(lbqm_pkg::BLOCK_BYTES - 1) ||
                wd_ff.len == LEN_W'(1)) begin
               link_we  = 1'b1;
               ftop_in  = cur_ff;
               fcnt_in  = fcnt_ff + 1'b1;
               state_in = S_DLNK;
            end
         end
         S_DLNK: begin
            cur_in   = link_q;
            off_in   = '0;
            state_in = S_DCHK;
         end
         S_DCHK: begin
            if (nval_ff == 4'd8 || idx_ff == nmax_ff) begin
               wd_in.head = cur_ff;
               wd_in.off  = (wd_ff.len == '0) ? '0 : off_ff[OFF_W-1:0];
               last_in    = (idx_ff == nmax_ff);
               state_in   = S_EMIT;
            end else begin
               state_in = S_DRD;
            end
         end
         S_EMIT: begin
            if (slot) begin
               rsp_in.status = status_ff;
               rsp_in.data   = acc_ff;
               rsp_in.nbytes = nval_ff;
               rsp_in.last   = last_ff;
               rsp_in.total  = cmd_ff.bad ? '0 : wd_ff.len;
               rsp_in.free   = fcnt_ff;
               rvld_in       = 1'b1;
               desc_we       = !cmd_ff.bad;
               acc_in        = '0;
               nval_in       = '0;
               state_in      = last_ff ? S_IDLE : S_DRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         clr_ff   <= '0;
         rvld_ff  <= 1'b0;
         ftop_ff  <= BLK_W'(lbqm_pkg::NUM_BLOCKS - 1);
         fcnt_ff  <= FREE_W'(lbqm_pkg::NUM_BLOCKS);
         chain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rvld_ff  <= rvld_in;
         ftop_ff  <= ftop_in;
         fcnt_ff  <= fcnt_in;
         chain_ff <= chain_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      wd_ff     <= wd_in;
      cur_ff    <= cur_in;
      off_ff    <= off_in;
      idx_ff    <= idx_in;
      nmax_ff   <= nmax_in;
      acc_ff    <= acc_in;
      nval_ff   <= nval_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // descriptor memory
   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_mem[desc_waddr] <= desc_wdata;
      end
      desc_q <= desc_mem[desc_raddr];
   end

   // link memory, read returns the old entry on a same-address write
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_q <= link_mem[link_raddr];
   end

   // byte store
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_waddr] <= data_wdata;
      end
      data_q <= data_mem[data_raddr];
   end

endmodule

// ----- design/linked_block_queue_manager_core.sv -----
// Put: descriptor read, then bytes written one by one, a free-stack pop per block taken; an
// empty or rejected put goes straight to the response. Drain: bytes read one by one, the link
// followed where a block is freed, packed into 8-byte beats; clear and quota: a descriptor
// update. One item at a time in the back sequencer, bound by one byte store access per
// cycle. A two-entry command queue takes new transactions while the back works. Synchronous
// reset; then a pass builds the free stack and zeroes the queue descriptors first.
module linked_block_queue_manager_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // queue_index, put_bytes, put_count, drain_capacity, quota_value, zero pad
   input  logic [103:0] req_tdata,
   // req_type
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, out_data, out_valid_bytes, queued_total, free_left, zero pad
   output logic [103:0] rsp_tdata,
   output logic         rsp_tlast
);

   logic              cmd_valid;
   logic              cmd_pop;
   lbqm_pkg::cmd_type cmd;
   lbqm_pkg::rsp_type rsp;

   lbqm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_queue  (req_tdata[7:0]),
      .in_bytes  (req_tdata[71:8]),
      .in_cnt    (req_tdata[75:72]),
      .in_cap    (req_tdata[82:76]),
      .in_quota  (req_tdata[100:83]),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   lbqm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the response transaction
   assign rsp_tdata = {6'd0, rsp.free, rsp.total, rsp.nbytes, rsp.data, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule
